/* rtl/sast_pkg.sv */
`default_nettype none

package sast_pkg;

  localparam int SET_BITS   = 4;
  localparam int WAYS       = 4;
  localparam int DATA_WIDTH = 32;
  localparam int KEY_WIDTH  = 32;

  localparam int NUM_SETS  = 1 << SET_BITS;
  localparam int TAG_WIDTH = KEY_WIDTH - SET_BITS;
  localparam int WAY_BITS  = $clog2(WAYS);
  localparam int WAY_IDX_W = 3;

  localparam int S_TDATA_W  = ((KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8;
  localparam int M_FIELDS_W = WAY_IDX_W + DATA_WIDTH;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_TUSER_W  = 2;

  localparam logic [WAY_IDX_W-1:0] WAY_NONE = WAY_IDX_W'(WAYS);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [SET_BITS-1:0]   set;
    logic [TAG_WIDTH-1:0]  tag;
    logic [DATA_WIDTH-1:0] data;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [WAY_IDX_W-1:0]  way;
    logic [DATA_WIDTH-1:0] read_data;
    logic                  allocated;
  } resp_t;

endpackage

`default_nettype wire

/* rtl/set_assoc_signature_table_core.sv */
// set-associative signature table, 16 sets of 4 ways, age-based replacement
//
// input stream s_*: one request per handshake, opcode in s_tuser (0 lookup,
// 1 fill), signature in s_tdata[31:0], fill data in s_tdata[63:32]
// output stream m_*: one result per request, in order; m_tuser holds hit
// and allocated, m_tdata holds way_index then read_data
//
// a request is held in a two-entry queue, then the set row is read from the
// tag and data memories, and the set is updated in S_EXEC once the output
// register is free to take the result; the back end takes a new request
// only after it has executed the last, since the registered memory read
// must complete before the read-modify-write of the same set
//
// reset: all entries invalid, ages equal to the way number, queue empty;
// tags and data are not cleared, no clearing pass is needed
// a stalled m_tready holds the result; the queue keeps taking requests until
// it is full, then s_tready drops
`default_nettype none

module set_assoc_signature_table_core
  import sast_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // signature, fill_data
  input  wire logic                 s_tuser,   // opcode
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata,   // way_index, read_data
  output logic      [M_TUSER_W-1:0] m_tuser    // hit, allocated
);

  logic q_valid;
  logic q_pop;
  req_t q_req;

  sast_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  sast_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  a_hit_alloc_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("hit and allocation reported together");

  a_miss_way: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0] && !m_tuser[1]) |-> (m_tdata[WAY_IDX_W-1:0] == WAY_NONE))
    else $error("lookup miss without the no-way code");

  a_data_on_hit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[WAY_IDX_W +: DATA_WIDTH] != '0)) |-> (m_tuser[0] && !m_tuser[1]))
    else $error("read data returned without a hit");

  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_valid)
    else $error("queue stalls input while empty");
`endif

endmodule

`default_nettype wire

/* rtl/sast_ram.sv */
`default_nettype none

module sast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/sast_front.sv */
`default_nettype none

module sast_front
  import sast_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // signature, fill_data
  input  wire logic                 s_tuser,   // opcode
  output logic                      q_valid,
  output req_t                      q_req,
  input  wire logic                 q_pop
);

  req_t       slot [2];
  req_t       dec;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  // split the key into set and tag, and take the opcode and fill data
  always_comb begin
    dec.op   = op_t'(s_tuser);
    dec.set  = s_tdata[SET_BITS-1:0];
    dec.tag  = s_tdata[KEY_WIDTH-1:SET_BITS];
    dec.data = s_tdata[KEY_WIDTH +: DATA_WIDTH];
  end

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_req    = slot[rd_ptr];
  assign push     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/sast_back.sv */
`default_nettype none

module sast_back
  import sast_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire req_t                 q_req,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata,   // way_index, read_data
  output logic      [M_TUSER_W-1:0] m_tuser    // hit, allocated
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  req_t   cur;
  resp_t  out;
  resp_t  resp;

  logic [NUM_SETS-1:0][WAYS-1:0]               valid_q;
  logic [NUM_SETS-1:0][WAYS-1:0][WAY_BITS-1:0] age_q;

  logic [WAYS*TAG_WIDTH-1:0]  tag_row;
  logic [WAYS*DATA_WIDTH-1:0] data_row;
  logic [WAYS*TAG_WIDTH-1:0]  tag_row_next;
  logic [WAYS*DATA_WIDTH-1:0] data_row_next;
  logic [WAYS-1:0]               valid_row;
  logic [WAYS-1:0]               valid_row_next;
  logic [WAYS-1:0][WAY_BITS-1:0] age_row;
  logic [WAYS-1:0][WAY_BITS-1:0] age_row_next;

  logic                exec_go;
  logic                tag_wr;
  logic                data_wr;
  logic                any_hit;
  logic                any_free;
  logic [WAY_BITS-1:0] hit_way;
  logic [WAY_BITS-1:0] free_way;
  logic [WAY_BITS-1:0] old_way;
  logic [WAY_BITS-1:0] victim;
  logic [WAY_BITS-1:0] sel_way;
  logic                alloc;

  assign q_pop   = (state == S_IDLE) && q_valid;
  assign exec_go = (state == S_EXEC) && (!m_tvalid || m_tready);

  sast_ram #(.WIDTH(WAYS*TAG_WIDTH), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_wr),
    .wr_addr (cur.set),
    .wr_data (tag_row_next),
    .rd_en   (q_pop),
    .rd_addr (q_req.set),
    .rd_data (tag_row)
  );

  sast_ram #(.WIDTH(WAYS*DATA_WIDTH), .DEPTH(NUM_SETS)) u_data_ram (
    .clk     (clk),
    .wr_en   (data_wr),
    .wr_addr (cur.set),
    .wr_data (data_row_next),
    .rd_en   (q_pop),
    .rd_addr (q_req.set),
    .rd_data (data_row)
  );

  assign valid_row = valid_q[cur.set];
  assign age_row   = age_q[cur.set];

  // tag match and victim choice over the ways of the set
  always_comb begin
    any_hit  = 1'b0;
    any_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_row[w] && (tag_row[w*TAG_WIDTH +: TAG_WIDTH] == cur.tag)) begin
        any_hit = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!valid_row[w]) begin
        any_free = 1'b1;
        free_way = WAY_BITS'(w);
      end
      // ages stay a permutation, so the oldest holds the top age
      if (age_row[w] == WAY_BITS'(WAYS - 1)) begin
        old_way = WAY_BITS'(w);
      end
    end
    victim  = any_free ? free_way : old_way;
    alloc   = (cur.op == OP_FILL) && !any_hit;
    sel_way = any_hit ? hit_way : victim;
  end

  always_comb begin
    tag_row_next   = tag_row;
    data_row_next  = data_row;
    valid_row_next = valid_row;
    age_row_next   = age_row;
    tag_row_next[victim*TAG_WIDTH +: TAG_WIDTH]    = cur.tag;
    data_row_next[sel_way*DATA_WIDTH +: DATA_WIDTH] = cur.data;
    valid_row_next[victim] = 1'b1;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_BITS'(w) == victim) begin
        age_row_next[w] = '0;
      end else if (age_row[w] < age_row[victim]) begin
        age_row_next[w] = age_row[w] + 1'b1;
      end
    end
  end

  assign tag_wr  = exec_go && alloc;
  assign data_wr = exec_go && (cur.op == OP_FILL);

  always_comb begin
    resp.hit       = any_hit;
    resp.allocated = alloc;
    resp.way       = (any_hit || alloc) ? WAY_IDX_W'(sel_way) : WAY_NONE;
    resp.read_data = (any_hit && (cur.op == OP_LOOKUP))
                     ? data_row[hit_way*DATA_WIDTH +: DATA_WIDTH] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      valid_q  <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          age_q[s][w] <= WAY_BITS'(w);
        end
      end
    end else begin
      if (exec_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            out   <= resp;
            state <= S_IDLE;
            if (alloc) begin
              valid_q[cur.set] <= valid_row_next;
              age_q[cur.set]   <= age_row_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = M_TDATA_W'({out.read_data, out.way});
  assign m_tuser = {out.allocated, out.hit};

endmodule

`default_nettype wire
